// ----- rtl/core/tpcd_pkg.sv -----
// Shared types and constants for the timebase, breathing PWM and charge detect block.
`timescale 1ns / 1ps
`default_nettype none

package tpcd_pkg;

   // Event kinds carried by the action field
   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_EDGE = 1'b1;

   // Breathing LED
   localparam logic [3:0]  PWM_PERIOD        = 4'd12;
   localparam logic [10:0] BREATH_STEP_TICKS = 11'd1600;
   localparam logic [3:0]  DUTY_RESET        = 4'd10;
   localparam logic [3:0]  DUTY_FLOOR        = 4'd1;

   // Timebase
   localparam logic [5:0] TICKS_PER_PERIOD    = 6'd40;
   localparam logic [7:0] PERIODS_PER_SECOND  = 8'd250;
   localparam logic [6:0] HALF_SECOND_PERIODS = 7'd125;
   localparam logic [5:0] MINUTE_SECONDS      = 6'd60;
   localparam logic [2:0] IDLE_CLEAR_SECONDS  = 3'd5;

   // Task strobe decode on the 4 ms count
   localparam logic [3:0] ADC_ENABLE_NIBBLE   = 4'he;
   localparam logic [3:0] BATTERY_TASK_NIBBLE = 4'hf;
   localparam logic [1:0] ADC_TASK_BITS       = 2'h3;

   // Configuration register reset values
   localparam logic [7:0]  CHARGE_FULL_MINUTES_RESET = 8'd60;
   localparam logic [15:0] PULSE_GAP_LOW_RESET       = 16'd170;
   localparam logic [15:0] PULSE_GAP_HIGH_RESET      = 16'd350;

   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CHARGE_FULL_MINUTES = 2'd0,
      CSR_PULSE_GAP_LOW       = 2'd1,
      CSR_PULSE_GAP_HIGH      = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  charge_full_minutes;
      logic [15:0] pulse_gap_low;
      logic [15:0] pulse_gap_high;
   } cfg_type;

   typedef struct packed {
      logic action;
      logic breathe_enable;
      logic battery_low;
      logic battery_above_4v1;
      logic standby_mode;
   } req_item_type;

   // Timebase and charge detect results for one transaction
   typedef struct packed {
      logic        adc_enable_strobe;
      logic        battery_task_strobe;
      logic        adc_task_strobe;
      logic        buzzer_task_strobe;
      logic        key_task_strobe;
      logic        half_second_strobe;
      logic        five_second_strobe;
      logic        charging;
      logic        charge_full;
      logic [15:0] sleep_seconds;
      logic [15:0] low_battery_seconds;
   } tb_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/tpcd_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps
`default_nettype none

interface tpcd_req_if;
   logic valid;
   logic ready;
   logic action;
   logic breathe_enable;
   logic battery_low;
   logic battery_above_4v1;
   logic standby_mode;

   modport source (
      output valid, action, breathe_enable, battery_low, battery_above_4v1, standby_mode,
      input  ready
   );
   modport sink (
      input  valid, action, breathe_enable, battery_low, battery_above_4v1, standby_mode,
      output ready
   );
endinterface

interface tpcd_rsp_if;
   logic        valid;
   logic        ready;
   logic        led_level;
   logic        adc_enable_strobe;
   logic        battery_task_strobe;
   logic        adc_task_strobe;
   logic        buzzer_task_strobe;
   logic        key_task_strobe;
   logic        half_second_strobe;
   logic        five_second_strobe;
   logic        charging;
   logic        charge_full;
   logic [15:0] sleep_seconds;
   logic [15:0] low_battery_seconds;

   modport source (
      output valid, led_level, adc_enable_strobe, battery_task_strobe, adc_task_strobe,
             buzzer_task_strobe, key_task_strobe, half_second_strobe, five_second_strobe,
             charging, charge_full, sleep_seconds, low_battery_seconds,
      input  ready
   );
   modport sink (
      input  valid, led_level, adc_enable_strobe, battery_task_strobe, adc_task_strobe,
             buzzer_task_strobe, key_task_strobe, half_second_strobe, five_second_strobe,
             charging, charge_full, sleep_seconds, low_battery_seconds,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/core/tpcd_breath.sv -----
// Breathing LED: PWM phase counter with a duty that ramps up and down.
`timescale 1ns / 1ps
`default_nettype none

module tpcd_breath
   import tpcd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step_en,
   output logic      led_in
);

   logic [3:0]  phase_ff, phase_in, phase_v;
   logic [10:0] breath_ff, breath_in, breath_v;
   logic [3:0]  duty_ff, duty_in, duty_v;
   logic        ramp_down_ff, ramp_down_in, ramp_down_v;
   logic        led_ff, led_v;

   // Work out one PWM step
   always_comb begin
      phase_v     = phase_ff + 4'd1;
      breath_v    = (breath_ff != '1) ? breath_ff + 11'd1 : breath_ff;
      duty_v      = duty_ff;
      ramp_down_v = ramp_down_ff;
      led_v       = led_ff;

      if (phase_v == duty_ff) begin
         led_v = 1'b1;
      end
      if (phase_v >= PWM_PERIOD) begin
         led_v   = 1'b0;
         phase_v = '0;
      end

      // Move the duty one step at the end of each breath interval
      if (breath_v >= BREATH_STEP_TICKS) begin
         breath_v = '0;
         if (!ramp_down_ff) begin
            if (duty_ff != '1) begin
               duty_v = duty_ff + 4'd1;
            end
            if (duty_v >= PWM_PERIOD) begin
               ramp_down_v = 1'b1;
            end
         end else begin
            if (duty_ff != '0) begin
               duty_v = duty_ff - 4'd1;
            end
            if (duty_v <= DUTY_FLOOR) begin
               ramp_down_v = 1'b0;
            end
         end
      end
   end

   // Hold everything unless a breathing tick arrives
   always_comb begin
      phase_in     = step_en ? phase_v     : phase_ff;
      breath_in    = step_en ? breath_v    : breath_ff;
      duty_in      = step_en ? duty_v      : duty_ff;
      ramp_down_in = step_en ? ramp_down_v : ramp_down_ff;
      led_in       = step_en ? led_v       : led_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         breath_ff    <= '0;
         duty_ff      <= DUTY_RESET;
         ramp_down_ff <= 1'b0;
         led_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         breath_ff    <= breath_in;
         duty_ff      <= duty_in;
         ramp_down_ff <= ramp_down_in;
         led_ff       <= led_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/tpcd_timebase.sv -----
// Tick divider, task strobes, saturating time counters and charger pulse detector.
`timescale 1ns / 1ps
`default_nettype none

module tpcd_timebase
   import tpcd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step_en,
   input  wire req_item_type  item,
   input  wire cfg_type       cfg,
   output tb_result_type      result
);

   logic [5:0]  tick_ff, tick_in, tick_inc;
   logic [7:0]  period_ff, period_in, period_inc;
   logic [6:0]  half_ff, half_in, half_inc;
   logic [5:0]  minute_sec_ff, minute_sec_in, sec_v;
   logic [2:0]  idle_ff, idle_in, idle_v;
   logic [15:0] edge_gap_ff, edge_gap_in;
   logic [1:0]  valid_pulses_ff, valid_pulses_in;
   logic        charging_ff, charging_in;
   logic [7:0]  full_minutes_ff, full_minutes_in, full_minutes_v;
   logic        full_ff, full_in;
   logic [15:0] sleep_ff, sleep_in;
   logic [15:0] low_batt_ff, low_batt_in;
   logic        gap_ok;

   function automatic logic multiple_of_five(input logic [5:0] value);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= 12; k++) begin
         if (value == 6'(5 * k)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   assign gap_ok = (edge_gap_ff > cfg.pulse_gap_low) && (edge_gap_ff < cfg.pulse_gap_high);

   // Next state and strobes for one transaction
   always_comb begin
      tick_ff_hold: begin
         tick_in         = tick_ff;
         period_in       = period_ff;
         half_in         = half_ff;
         minute_sec_in   = minute_sec_ff;
         idle_in         = idle_ff;
         edge_gap_in     = edge_gap_ff;
         valid_pulses_in = valid_pulses_ff;
         charging_in     = charging_ff;
         full_minutes_in = full_minutes_ff;
         full_in         = full_ff;
         sleep_in        = sleep_ff;
         low_batt_in     = low_batt_ff;
      end
      tick_inc       = tick_ff + 6'd1;
      period_inc     = period_ff + 8'd1;
      half_inc       = half_ff + 7'd1;
      sec_v          = minute_sec_ff;
      idle_v         = idle_ff;
      full_minutes_v = full_minutes_ff;

      result.adc_enable_strobe   = 1'b0;
      result.battery_task_strobe = 1'b0;
      result.adc_task_strobe     = 1'b0;
      result.buzzer_task_strobe  = 1'b0;
      result.key_task_strobe     = 1'b0;
      result.half_second_strobe  = 1'b0;
      result.five_second_strobe  = 1'b0;

      if (step_en) begin
         if (item.action == ACTION_EDGE) begin
            // Check the gap since the previous charger edge
            if (gap_ok) begin
               if (valid_pulses_ff >= 2'd2) begin
                  charging_in = 1'b1;
               end
               if (valid_pulses_ff != '1) begin
                  valid_pulses_in = valid_pulses_ff + 2'd1;
               end
               idle_in = '0;
            end
            sleep_in    = '0;
            edge_gap_in = '0;
         end else begin
            tick_in = tick_inc;
            if (tick_inc >= TICKS_PER_PERIOD) begin
               // End of a 4 ms period
               tick_in   = '0;
               period_in = period_inc;
               half_in   = half_inc;
               result.adc_enable_strobe   = (period_inc[3:0] == ADC_ENABLE_NIBBLE);
               result.battery_task_strobe = (period_inc[3:0] == BATTERY_TASK_NIBBLE);
               result.adc_task_strobe     = (period_inc[1:0] == ADC_TASK_BITS);
               result.buzzer_task_strobe  = 1'b1;
               result.key_task_strobe     = period_inc[1];
               if (edge_gap_ff != '1) begin
                  edge_gap_in = edge_gap_ff + 16'd1;
               end

               // End of a second
               if (period_inc >= PERIODS_PER_SECOND) begin
                  period_in = '0;
                  sec_v     = minute_sec_ff + 6'd1;
                  idle_v    = idle_ff + 3'd1;
                  if (item.standby_mode && sleep_ff != '1) begin
                     sleep_in = sleep_ff + 16'd1;
                  end
                  if (item.battery_low && low_batt_ff != '1) begin
                     low_batt_in = low_batt_ff + 16'd1;
                  end
                  result.five_second_strobe = multiple_of_five(sec_v);
               end

               if (half_inc >= HALF_SECOND_PERIODS) begin
                  result.half_second_strobe = 1'b1;
                  half_in = '0;
               end

               // Drop charging after too long without a valid pulse
               if (idle_v >= IDLE_CLEAR_SECONDS) begin
                  idle_in         = '0;
                  valid_pulses_in = '0;
                  charging_in     = 1'b0;
               end else begin
                  idle_in = idle_v;
               end

               // End of a minute: count charge-full time
               if (sec_v >= MINUTE_SECONDS) begin
                  minute_sec_in = '0;
                  if (item.battery_above_4v1) begin
                     if (full_minutes_ff != '1) begin
                        full_minutes_v = full_minutes_ff + 8'd1;
                     end
                     if (full_minutes_v >= cfg.charge_full_minutes) begin
                        full_in = 1'b1;
                     end
                     full_minutes_in = full_minutes_v;
                  end
               end else begin
                  minute_sec_in = sec_v;
               end
            end
         end
      end

      result.charging            = charging_in;
      result.charge_full         = full_in;
      result.sleep_seconds       = sleep_in;
      result.low_battery_seconds = low_batt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         period_ff       <= '0;
         half_ff         <= '0;
         minute_sec_ff   <= '0;
         idle_ff         <= '0;
         edge_gap_ff     <= '0;
         valid_pulses_ff <= '0;
         charging_ff     <= 1'b0;
         full_minutes_ff <= '0;
         full_ff         <= 1'b0;
         sleep_ff        <= '0;
         low_batt_ff     <= '0;
      end else begin
         tick_ff         <= tick_in;
         period_ff       <= period_in;
         half_ff         <= half_in;
         minute_sec_ff   <= minute_sec_in;
         idle_ff         <= idle_in;
         edge_gap_ff     <= edge_gap_in;
         valid_pulses_ff <= valid_pulses_in;
         charging_ff     <= charging_in;
         full_minutes_ff <= full_minutes_in;
         full_ff         <= full_in;
         sleep_ff        <= sleep_in;
         low_batt_ff     <= low_batt_in;
      end
   end

   // Charging is only ever set together with the pulse count reaching its limit
   assert property (@(posedge clock) disable iff (reset)
      charging_ff |-> (valid_pulses_ff == 2'd3))
      else $error("charging set without three valid pulses");

   // Charge-full flag is sticky
   assert property (@(posedge clock) disable iff (reset)
      full_ff |=> full_ff)
      else $error("charge-full flag dropped");

   // Seconds only advance as the 4 ms count rolls over
   assert property (@(posedge clock) disable iff (reset)
      !$stable(minute_sec_ff) && !$past(reset) |-> (period_ff == '0) && (tick_ff == '0))
      else $error("second count moved off a period boundary");

   // Edge gap clears on every charger edge
   assert property (@(posedge clock) disable iff (reset)
      step_en && item.action == ACTION_EDGE |=> edge_gap_ff == '0)
      else $error("edge gap not cleared on edge");

endmodule

`default_nettype wire

// ----- rtl/core/timebase_breath_pwm_charge_detect_top.sv -----
// Top level: input and result registers, configuration registers, breathing LED and timebase.
//
// Request channel (req_ch): one transaction is either a 100 us tick (action 0) or a
// charger line edge (action 1), with the status inputs sampled along with it.
// Response channel (rsp_ch): exactly one result transaction per request: LED drive,
// task strobes, charging and charge-full flags, sleep and low-battery seconds.
// Configuration (csr_*): write-only registers, index 0 charge-full minutes, 1 low gap
// bound, 2 high gap bound; the user must write them only while no transaction is in
// flight; the block itself does not enforce this. An accepted request is registered,
// processed once the result register is free, and its result registered for rsp_ch.
// Throughput: one transaction per cycle while rsp_ch.ready holds; the state update
// is a single pass of short counter logic between the request and result registers.
// Reset (synchronous, active high) clears all counters and flags, sets the duty to
// ten and loads the configuration defaults 60, 170 and 350.
// When the receiver stalls, the result register holds its transaction and one more
// request still sits in the request register; req_ch.ready then drops until
// the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module timebase_breath_pwm_charge_detect_top
   import tpcd_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   tpcd_req_if.sink                        req_ch,
   tpcd_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   cfg_type       cfg_ff, cfg_in;
   logic          req_valid_ff, req_valid_in;
   req_item_type  req_item_ff, req_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          advance;
   logic          breath_step;
   logic          led_in;
   logic          led_level_ff;
   tb_result_type tb_result;
   tb_result_type tb_result_ff;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CHARGE_FULL_MINUTES: cfg_in.charge_full_minutes = csr_wr_data[7:0];
            CSR_PULSE_GAP_LOW:       cfg_in.pulse_gap_low       = csr_wr_data;
            CSR_PULSE_GAP_HIGH:      cfg_in.pulse_gap_high      = csr_wr_data;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Advance the registered request when the result register is free
   assign advance      = req_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !req_valid_ff || advance;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_ch.ready) begin
         req_valid_in                  = req_ch.valid;
         req_item_in.action            = req_ch.action;
         req_item_in.breathe_enable    = req_ch.breathe_enable;
         req_item_in.battery_low       = req_ch.battery_low;
         req_item_in.battery_above_4v1 = req_ch.battery_above_4v1;
         req_item_in.standby_mode      = req_ch.standby_mode;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign breath_step = advance && (req_item_ff.action == ACTION_TICK)
                        && req_item_ff.breathe_enable;

   tpcd_breath u_breath (
      .clock   (clock),
      .reset   (reset),
      .step_en (breath_step),
      .led_in  (led_in)
   );

   tpcd_timebase u_timebase (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (req_item_ff),
      .cfg     (cfg_ff),
      .result  (tb_result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff               <= 1'b0;
         rsp_valid_ff               <= 1'b0;
         cfg_ff.charge_full_minutes <= CHARGE_FULL_MINUTES_RESET;
         cfg_ff.pulse_gap_low       <= PULSE_GAP_LOW_RESET;
         cfg_ff.pulse_gap_high      <= PULSE_GAP_HIGH_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      if (advance) begin
         led_level_ff <= led_in;
         tb_result_ff <= tb_result;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.led_level           = led_level_ff;
   assign rsp_ch.adc_enable_strobe   = tb_result_ff.adc_enable_strobe;
   assign rsp_ch.battery_task_strobe = tb_result_ff.battery_task_strobe;
   assign rsp_ch.adc_task_strobe     = tb_result_ff.adc_task_strobe;
   assign rsp_ch.buzzer_task_strobe  = tb_result_ff.buzzer_task_strobe;
   assign rsp_ch.key_task_strobe     = tb_result_ff.key_task_strobe;
   assign rsp_ch.half_second_strobe  = tb_result_ff.half_second_strobe;
   assign rsp_ch.five_second_strobe  = tb_result_ff.five_second_strobe;
   assign rsp_ch.charging            = tb_result_ff.charging;
   assign rsp_ch.charge_full         = tb_result_ff.charge_full;
   assign rsp_ch.sleep_seconds       = tb_result_ff.sleep_seconds;
   assign rsp_ch.low_battery_seconds = tb_result_ff.low_battery_seconds;

endmodule

`default_nettype wire
